>>> rtl/uudecode_stream_core_defines.svh
// Assertion macros for the uudecode stream core checker.
// Used by uud_checker.sv; depends on nothing else.
`ifndef UUDECODE_STREAM_CORE_DEFINES_SVH
`define UUDECODE_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UUD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UUD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/uud_pkg.sv
// Types and constants of the uudecode stream core.
// No dependencies; used by the decode step and the top level.
`timescale 1ns / 1ps

package uud_pkg;

	typedef enum logic [3:0] {
		PH_LEN  = 4'b0001,
		PH_BODY = 4'b0010,
		PH_NL   = 4'b0100,
		PH_IDLE = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_DATA = 2'd0,
		ST_OK   = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	// Lines of at least this many bytes are followed by another line.
	localparam logic [5:0] LONG_LINE = 6'd45;
	// ceil(v/3) = ((v + 2) * 43) >> 7, exact for v + 2 below 128.
	localparam logic [12:0] THIRD_MUL = 13'd43;
	localparam int unsigned THIRD_SHIFT = 7;

	typedef struct packed {
		phase_t      phase;
		logic [5:0]  line_left;
		logic [6:0]  body_left;
		logic [1:0]  quad;
		logic [17:0] store;
		logic        final_line;
	} uud_state_t;

	// Results caused by one character: data bytes first, then an optional status.
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      nbytes;
		logic            has_status;
		status_t         status;
	} uud_batch_t;

	localparam uud_state_t STATE_REARM = '{
		phase: PH_LEN, line_left: 6'd0, body_left: 7'd0,
		quad: 2'd0, store: 18'd0, final_line: 1'b0
	};

	function automatic logic [5:0] sextet(input logic [7:0] c);
		// (c - 32) & 63 only flips bit 5 of the low six bits.
		sextet = {~c[5], c[4:0]};
	endfunction

endpackage

>>> rtl/uud_char_if.sv
// Input channel of the uudecode stream core: one character per word.
// No dependencies.
`timescale 1ns / 1ps

interface uud_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_text;

	modport source (output valid, output char_in, output end_of_text, input ready);
	modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

>>> rtl/uud_res_if.sv
// Result channel of the uudecode stream core: one decoded byte or status per word.
// No dependencies.
`timescale 1ns / 1ps

interface uud_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [1:0] status;
	logic       last_of_run;

	modport source (output valid, output byte_out, output status, output last_of_run,
		input ready);
	modport sink (input valid, input byte_out, input status, input last_of_run,
		output ready);
endinterface

>>> rtl/uudecode_stream_core.sv
// Top level of the uudecode stream core: state registers, result buffers, output mux.
// Depends on uud_pkg, uud_char_if, uud_res_if and uud_step.
//
//   channel | interface   | word                            | direction
//   chars   | uud_char_if | char_in, end_of_text            | in
//   res     | uud_res_if  | byte_out, status, last_of_run   | out
//
// One character is accepted per cycle; its state update and results are found in that cycle.
// Its 0 to 4 results go to a result register and a second holding register, one leaves per cycle.
// A character completing a group of four gives up to three bytes, plus a status at message end.
// chars.ready falls only while both holding registers are full, e.g. on a stalled output.
// Reset (arst_n low) clears the decode state and marks both holding registers empty at once.
`timescale 1ns / 1ps

module uudecode_stream_core (
	input logic         clk,
	input logic         arst_n,
	uud_char_if.sink    chars,
	uud_res_if.source   res
);
	import uud_pkg::*;

	uud_state_t state_q;
	uud_state_t nxt_state;
	uud_batch_t new_batch;
	uud_batch_t cur_s1;
	uud_batch_t pend_q;
	logic       cur_vld_q;
	logic       pend_vld_q;
	logic [1:0] ptr_q;

	logic       in_acc;
	logic       out_acc;
	logic       new_has;
	logic [2:0] cur_total;
	logic       cur_last;
	logic       cur_free;
	logic       load_direct;

	uud_step u_step (
		.cur         (state_q),
		.char_in     (chars.char_in),
		.end_of_text (chars.end_of_text),
		.nxt         (nxt_state),
		.batch       (new_batch)
	);

	assign chars.ready = !pend_vld_q;
	assign in_acc      = chars.valid && chars.ready;
	assign new_has     = (new_batch.nbytes != 2'd0) || new_batch.has_status;

	assign cur_total   = {1'b0, cur_s1.nbytes} + {2'b00, cur_s1.has_status};
	assign cur_last    = (({1'b0, ptr_q} + 3'd1) == cur_total);
	assign out_acc     = res.valid && res.ready;
	assign cur_free    = !cur_vld_q || (out_acc && cur_last);
	assign load_direct = cur_free && !pend_vld_q;

	always_comb begin
		res.valid       = cur_vld_q;
		res.last_of_run = cur_last;
		if ({1'b0, ptr_q} < {1'b0, cur_s1.nbytes}) begin
			res.status = ST_DATA;
			case (ptr_q)
				2'd0:    res.byte_out = cur_s1.data[0];
				2'd1:    res.byte_out = cur_s1.data[1];
				default: res.byte_out = cur_s1.data[2];
			endcase
		end else begin
			res.status   = cur_s1.status;
			res.byte_out = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= STATE_REARM;
			cur_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
			ptr_q      <= 2'd0;
		end else begin
			if (in_acc) begin
				state_q <= nxt_state;
			end
			if (cur_free) begin
				ptr_q <= 2'd0;
				if (pend_vld_q) begin
					cur_vld_q  <= 1'b1;
					pend_vld_q <= 1'b0;
				end else begin
					cur_vld_q <= in_acc && new_has;
				end
			end else if (out_acc) begin
				ptr_q <= ptr_q + 2'd1;
			end
			if (in_acc && new_has && !load_direct) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_free) begin
			cur_s1 <= pend_vld_q ? pend_q : new_batch;
		end
		if (in_acc && !load_direct) begin
			pend_q <= new_batch;
		end
	end

endmodule

>>> rtl/uud_step.sv
// Decode step: next state and result batch for one input character.
// Depends on uud_pkg.
`timescale 1ns / 1ps

module uud_step (
	input  uud_pkg::uud_state_t cur,
	input  logic [7:0]          char_in,
	input  logic                end_of_text,
	output uud_pkg::uud_state_t nxt,
	output uud_pkg::uud_batch_t batch
);
	import uud_pkg::*;

	logic [5:0]  v;
	logic [23:0] group;
	logic [12:0] third_prod;
	logic [6:0]  body_len;
	logic [6:0]  body_dec;
	logic [1:0]  nb;

	always_comb begin
		v          = sextet(char_in);
		group      = {cur.store, v};
		third_prod = (13'({1'b0, v}) + 13'd2) * THIRD_MUL;
		body_len   = {third_prod[THIRD_SHIFT +: 5], 2'b00};
		body_dec   = (cur.body_left != 7'd0) ? (cur.body_left - 7'd1) : 7'd0;
		nb         = (cur.line_left >= 6'd3) ? 2'd3 : cur.line_left[1:0];

		nxt   = cur;
		batch = '0;
		batch.data[0] = group[23:16];
		batch.data[1] = group[15:8];
		batch.data[2] = group[7:0];

		case (cur.phase)
			PH_LEN: begin
				if (v == 6'd0) begin
					batch.has_status = 1'b1;
					batch.status     = ST_OK;
					nxt.phase        = PH_IDLE;
				end else if (end_of_text) begin
					batch.has_status = 1'b1;
					batch.status     = ST_ERR;
				end else begin
					nxt.line_left  = v;
					nxt.body_left  = body_len;
					nxt.quad       = 2'd0;
					nxt.store      = 18'd0;
					nxt.final_line = (v < LONG_LINE);
					nxt.phase      = PH_BODY;
				end
			end
			PH_BODY: begin
				if (cur.quad != 2'd3) begin
					nxt.store = {cur.store[11:0], v};
					nxt.quad  = cur.quad + 2'd1;
				end else begin
					// Only the bytes still owed by the line are sent.
					batch.nbytes  = nb;
					nxt.line_left = cur.line_left - {4'd0, nb};
					nxt.quad      = 2'd0;
					nxt.store     = 18'd0;
				end
				nxt.body_left = body_dec;
				if (body_dec == 7'd0) begin
					if (cur.final_line || end_of_text) begin
						batch.has_status = 1'b1;
						batch.status     = ST_OK;
						nxt.phase        = PH_IDLE;
					end else begin
						nxt.phase = PH_NL;
					end
				end else if (end_of_text) begin
					batch.has_status = 1'b1;
					batch.status     = ST_ERR;
				end
			end
			PH_NL: begin
				if (end_of_text) begin
					batch.has_status = 1'b1;
					batch.status     = ST_OK;
				end else begin
					nxt.phase = PH_LEN;
				end
			end
			PH_IDLE: begin
				nxt = cur;
			end
			default: begin
				nxt = cur;
			end
		endcase

		// A marked character always leaves the block expecting a length character.
		if (end_of_text) begin
			nxt = STATE_REARM;
		end
	end

endmodule

>>> rtl/uud_checker.sv
// Port-level checks of the uudecode stream core, bound to the top level.
// Depends on uudecode_stream_core_defines.svh and uud_pkg.
`timescale 1ns / 1ps
`include "uudecode_stream_core_defines.svh"

module uud_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] out_status,
	input logic       out_last
);
	import uud_pkg::*;

	`UUD_ASSERT_NXT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`UUD_ASSERT_NXT(a_out_word_hold, clk, arst_n, out_valid && !out_ready, $stable(out_byte) && $stable(out_status) && $stable(out_last), "stalled result word changed")
	`UUD_ASSERT_NXT(a_run_continues, clk, arst_n, out_valid && out_ready && !out_last, out_valid, "result run broken before its last word")
	`UUD_ASSERT_IMP(a_status_last, clk, arst_n, out_valid && (out_status != ST_DATA), out_last && (out_byte == 8'd0), "status word not last or carries a byte")
	`UUD_ASSERT_IMP(a_stall_has_output, clk, arst_n, !in_ready, out_valid, "input stalled with no result pending")

endmodule

bind uudecode_stream_core uud_checker u_uud_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (chars.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.out_byte   (res.byte_out),
	.out_status (res.status),
	.out_last   (res.last_of_run)
);
